FILE: src/skt_pkg.sv
// shared types and constants for the sorted key table
// no dependencies; imported by skt_slot and sorted_key_table_unit
package skt_pkg;

  // field widths of the transaction payload
  localparam int KEY_W     = 27;
  localparam int ACT_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;

  // default number of slots in the chain
  localparam int DEF_CAPACITY = 16;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef logic [KEY_W-1:0] key_t;

  // shift commands broadcast to every slot
  typedef struct packed {
    logic ins_en;  // shift up and drop the new key at the boundary
    logic rmv_en;  // shift down from the first match onward
  } skt_ctrl_t;

endpackage

FILE: src/sorted_key_table_unit.sv
// sorted key table: one transaction per cycle, result registered, valid the cycle after
// acceptance; throughput 1 transaction per cycle while not stalled; every slot compares
// with the key in parallel and shifts with its neighbor in the same cycle
// the result stage holds one transaction; input stalls only while that result is stalled
// synchronous active-low reset clears the entry count and the result valid;
// slot keys are not reset and are only read below the entry count
module sorted_key_table_unit #(
  parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [skt_pkg::ACT_W-1:0]     in_action,
  input  logic [skt_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [skt_pkg::STATUS_W-1:0]  out_status,
  output logic [skt_pkg::POS_W-1:0]     out_position,
  output logic [skt_pkg::COUNT_W-1:0]   out_count
);
  import skt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic [POS_W-1:0]    position_r;
  logic [POS_W-1:0]    position_nxt;
  logic [COUNT_W-1:0]  count_out_r;

  logic      fire;
  logic      full;
  logic      empty;
  logic      found;
  skt_ctrl_t ctrl;

  key_t               slot_key [CAPACITY];
  logic [CAPACITY-1:0] above;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] ins_hit;
  logic [CAPACITY-1:0] first_hit;
  logic [IDX_W-1:0]    ins_idx;
  logic [IDX_W-1:0]    find_idx;
  logic [IDX_W+POS_W-1:0] pos_wide;
  logic [CNT_W+COUNT_W-1:0] cnt_wide;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);
  assign found = |first_hit;

  // shift commands for the chain
  always_comb begin
    ctrl.ins_en = fire && (in_action == ACT_INSERT) && !full;
    ctrl.rmv_en = fire && (in_action == ACT_REMOVE) && !empty && found;
  end

  // chain of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic slot_valid;
    key_t left_key;
    key_t right_key;
    logic left_above;
    logic left_eq;

    assign slot_valid = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_key   = in_key;
      assign left_above = 1'b0;
      assign left_eq    = 1'b0;
    end else begin : g_mid
      assign left_key   = slot_key[i-1];
      assign left_above = above[i-1];
      assign left_eq    = eq[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = slot_key[i];
    end else begin : g_inner
      assign right_key = slot_key[i+1];
    end

    skt_slot u_slot (
      .clk         (clk),
      .ctrl        (ctrl),
      .key_in      (in_key),
      .slot_valid  (slot_valid),
      .left_key    (left_key),
      .left_above  (left_above),
      .left_eq     (left_eq),
      .right_key   (right_key),
      .key_o       (slot_key[i]),
      .above_o     (above[i]),
      .eq_o        (eq[i]),
      .ins_hit_o   (ins_hit[i]),
      .first_hit_o (first_hit[i])
    );
  end

  // one-hot hit vectors to slot index
  always_comb begin
    ins_idx  = '0;
    find_idx = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (ins_hit[j]) begin
        ins_idx = ins_idx | IDX_W'(j);
      end
      if (first_hit[j]) begin
        find_idx = find_idx | IDX_W'(j);
      end
    end
  end

  // result and next count
  always_comb begin
    status_nxt = ST_OK;
    pos_wide   = '0;
    count_nxt  = count_r;
    case (in_action)
      ACT_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          pos_wide  = {{POS_W{1'b0}}, ins_idx};
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_LOOKUP, ACT_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          pos_wide = {{POS_W{1'b0}}, find_idx};
          if (in_action == ACT_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    position_nxt = pos_wide[POS_W-1:0];
    cnt_wide     = {{COUNT_W{1'b0}}, count_nxt};
  end

  // count, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fire) begin
      status_r    <= status_nxt;
      position_r  <= position_nxt;
      count_out_r <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_position = position_r;
  assign out_count    = count_out_r;

endmodule

FILE: src/skt_slot.sv
// one slot of the sorted key chain: holds a key, compares it with the broadcast key
// depends on skt_pkg
module skt_slot (
  input  logic              clk,
  input  skt_pkg::skt_ctrl_t ctrl,
  input  skt_pkg::key_t     key_in,
  input  logic              slot_valid,
  input  skt_pkg::key_t     left_key,
  input  logic              left_above,
  input  logic              left_eq,
  input  skt_pkg::key_t     right_key,
  output skt_pkg::key_t     key_o,
  output logic              above_o,
  output logic              eq_o,
  output logic              ins_hit_o,
  output logic              first_hit_o
);
  import skt_pkg::*;

  key_t key_r;
  key_t key_nxt;

  // local compare against the broadcast key; an empty slot counts as above
  assign above_o     = !slot_valid || (key_r > key_in);
  assign eq_o        = slot_valid && (key_r == key_in);
  // insert boundary: first slot that is above the key
  assign ins_hit_o   = above_o && !left_above;
  // first equal key: equal keys are contiguous, so check the left neighbor only
  assign first_hit_o = eq_o && !left_eq;

  // shift logic
  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins_en) begin
      if (ins_hit_o) begin
        key_nxt = key_in;
      end else if (above_o) begin
        key_nxt = left_key;
      end
    end else if (ctrl.rmv_en) begin
      if (above_o || eq_o) begin
        key_nxt = right_key;
      end
    end
  end

  // key storage, no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o = key_r;

endmodule
